### sv/deq_pkg.sv
// Shared types and constants for the double-ended queue with search.
// Used by deq_ctrl, deq_dpath and the top level; depends on nothing.
package deq_pkg;

	localparam int unsigned DEPTH_DEFAULT = 16;
	localparam int unsigned VAL_W         = 32;
	localparam int unsigned FUNC_W        = 3;
	localparam int unsigned STAT_W        = 2;
	localparam int unsigned CNT_W         = 5;
	localparam int unsigned IN_W          = 40;
	localparam int unsigned OUT_W         = 40;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH_BACK  = 3'd0,
		FN_PUSH_FRONT = 3'd1,
		FN_POP_FRONT  = 3'd2,
		FN_POP_BACK   = 3'd3,
		FN_SEARCH     = 3'd4,
		FN_CLEAR      = 3'd5
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_RDWAIT,
		S_SRCH,
		S_DONE
	} state_t;

	typedef struct packed {
		logic latch_in;
		logic exec;
		logic rd_capture;
		logic srch_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  full;
		logic  empty;
		logic  srch_done;
		logic  out_free;
	} sts_t;

endpackage

### sv/double_ended_queue_with_search.sv
// Double-ended queue of signed 32-bit words with membership search.
// Built from deq_ctrl, deq_dpath and deq_ram; types from deq_pkg.
// Each word is executed, then its result is loaded once the output register is free;
// pops of a non-empty queue add a read wait, searches a scan to a match or the last entry.
// One word in flight; the next can be taken in the cycle after the result loads.
// arst_n clears pointers, count and handshake state; entry RAM is not cleared.
module double_ended_queue_with_search #(
	parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [deq_pkg::IN_W-1:0]   s_tdata,  // func[2:0], value[34:3], zero pad
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [deq_pkg::OUT_W-1:0]  m_tdata   // popped_value, found, status, count
);

	deq_pkg::cmd_t cmd;
	deq_pkg::sts_t sts;

	deq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	deq_dpath #(
		.DEPTH(DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

`ifndef NO_ASSERTIONS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second word accepted while one is in flight");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("result loaded over an untaken result");

	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(sts.full && sts.empty))
		else $error("queue both full and empty");

	a_exec_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch_in |=> cmd.exec)
		else $error("accepted word not executed");
`endif

endmodule

### sv/deq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module deq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/deq_ctrl.sv
// Request sequencer for the deque: accept, execute, read wait, search, deliver.
// Depends on deq_pkg.
module deq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  deq_pkg::sts_t  sts,
	output deq_pkg::cmd_t  cmd
);

	deq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= deq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			deq_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.latch_in = 1'b1;
					state_d      = deq_pkg::S_EXEC;
				end
			end
			deq_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = deq_pkg::S_DONE;
				if (!sts.empty) begin
					if (sts.func == deq_pkg::FN_POP_FRONT || sts.func == deq_pkg::FN_POP_BACK) begin
						state_d = deq_pkg::S_RDWAIT;
					end else if (sts.func == deq_pkg::FN_SEARCH) begin
						state_d = deq_pkg::S_SRCH;
					end
				end
			end
			deq_pkg::S_RDWAIT: begin
				cmd.rd_capture = 1'b1;
				state_d        = deq_pkg::S_DONE;
			end
			deq_pkg::S_SRCH: begin
				cmd.srch_step = 1'b1;
				if (sts.srch_done) begin
					state_d = deq_pkg::S_DONE;
				end
			end
			deq_pkg::S_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = deq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = deq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

### sv/deq_dpath.sv
// Deque datapath: ring pointers, entry RAM, search scan and output register.
// Depends on deq_pkg and deq_ram.
module deq_dpath #(
	parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [deq_pkg::IN_W-1:0]     s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [deq_pkg::OUT_W-1:0]    m_tdata,
	input  deq_pkg::cmd_t                cmd,
	output deq_pkg::sts_t                sts
);

	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	deq_pkg::func_t                    func_q;
	logic signed [deq_pkg::VAL_W-1:0]  value_q;
	logic [IW-1:0]                     front_q;
	logic [CW-1:0]                     count_q;
	logic [CW-1:0]                     scan_q;
	logic                              cmp_vld_s1;
	logic signed [deq_pkg::VAL_W-1:0]  res_popped_q;
	logic                              res_found_q;
	deq_pkg::status_t                  res_status_q;
	logic                              m_tvalid_q;
	logic [deq_pkg::OUT_W-1:0]         m_tdata_q;

	logic                              full, empty, issue, we;
	logic [IW-1:0]                     off, slot, front_dec, front_inc, waddr;
	logic [IW:0]                       sum;
	logic [CW-1:0]                     count_m1;
	logic [deq_pkg::VAL_W-1:0]         rdata;

	assign full      = count_q == CW'(DEPTH);
	assign empty     = count_q == '0;
	assign count_m1  = count_q - 1'b1;
	assign front_dec = (front_q == '0) ? IW'(DEPTH - 1) : front_q - 1'b1;
	assign front_inc = (front_q == IW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
	assign issue     = cmd.srch_step && (scan_q < count_q) && !res_found_q;

	always_comb begin
		priority if (cmd.srch_step) begin
			off = scan_q[IW-1:0];
		end else if (func_q == deq_pkg::FN_POP_BACK) begin
			off = count_m1[IW-1:0];
		end else if (func_q == deq_pkg::FN_PUSH_BACK) begin
			off = count_q[IW-1:0];
		end else begin
			off = '0;
		end
	end

	assign sum   = {1'b0, front_q} + {1'b0, off};
	assign slot  = (sum >= (IW+1)'(DEPTH)) ? IW'(sum - (IW+1)'(DEPTH)) : sum[IW-1:0];
	assign waddr = (func_q == deq_pkg::FN_PUSH_FRONT) ? front_dec : slot;
	assign we    = cmd.exec && !full &&
		(func_q == deq_pkg::FN_PUSH_BACK || func_q == deq_pkg::FN_PUSH_FRONT);

	deq_ram #(
		.WIDTH(deq_pkg::VAL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (value_q),
		.raddr (slot),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			func_q  <= deq_pkg::func_t'(s_tdata[deq_pkg::FUNC_W-1:0]);
			value_q <= s_tdata[deq_pkg::FUNC_W +: deq_pkg::VAL_W];
		end
		if (cmd.exec) begin
			res_popped_q <= '0;
			res_found_q  <= 1'b0;
			res_status_q <= deq_pkg::ST_OK;
			scan_q       <= '0;
			cmp_vld_s1   <= 1'b0;
			unique case (func_q)
				deq_pkg::FN_PUSH_BACK, deq_pkg::FN_PUSH_FRONT: begin
					if (full) begin
						res_status_q <= deq_pkg::ST_FULL;
					end
				end
				deq_pkg::FN_POP_FRONT, deq_pkg::FN_POP_BACK, deq_pkg::FN_SEARCH: begin
					if (empty) begin
						res_status_q <= deq_pkg::ST_EMPTY;
					end
				end
				default: begin
				end
			endcase
		end
		if (cmd.rd_capture) begin
			res_popped_q <= rdata;
		end
		if (cmd.srch_step) begin
			cmp_vld_s1 <= issue;
			if (issue) begin
				scan_q <= scan_q + 1'b1;
			end
			if (cmp_vld_s1 && rdata == value_q) begin
				res_found_q <= 1'b1;
			end
		end
		if (cmd.load_out) begin
			m_tdata_q <= {5'(count_q), res_status_q, res_found_q, res_popped_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q    <= '0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				unique case (func_q)
					deq_pkg::FN_PUSH_BACK: begin
						if (!full) begin
							count_q <= count_q + 1'b1;
						end
					end
					deq_pkg::FN_PUSH_FRONT: begin
						if (!full) begin
							front_q <= front_dec;
							count_q <= count_q + 1'b1;
						end
					end
					deq_pkg::FN_POP_FRONT: begin
						if (!empty) begin
							front_q <= front_inc;
							count_q <= count_m1;
						end
					end
					deq_pkg::FN_POP_BACK: begin
						if (!empty) begin
							count_q <= count_m1;
						end
					end
					deq_pkg::FN_CLEAR: begin
						front_q <= '0;
						count_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid      = m_tvalid_q;
	assign m_tdata       = m_tdata_q;
	assign sts.func      = func_q;
	assign sts.full      = full;
	assign sts.empty     = empty;
	assign sts.srch_done = !cmp_vld_s1 && ((scan_q == count_q) || res_found_q);
	assign sts.out_free  = !m_tvalid_q || m_tready;

endmodule

### test/tb.sv
// Testbench for double_ended_queue_with_search: a directed table, then random requests,
// each reply checked field by field against the table's expected word or an in-bench deque predictor.
// Depends on deq_pkg and the RTL of the block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          PERIOD      = 20;
	localparam int          DEPTH       = deq_pkg::DEPTH_DEFAULT;
	localparam int          VAL_W       = deq_pkg::VAL_W;
	localparam int          FUNC_W      = deq_pkg::FUNC_W;
	localparam int          STAT_W      = deq_pkg::STAT_W;
	localparam int          CNT_W       = deq_pkg::CNT_W;
	localparam int          IN_W        = deq_pkg::IN_W;
	localparam int          OUT_W       = deq_pkg::OUT_W;
	localparam int          RAND_ITEMS  = 1510;
	localparam int          PHASE_LEN   = 520;
	localparam int          HOLD_CYCLES = 400;
	localparam int          STALL_LIMIT = 5000;
	localparam logic [2:0]  FN_SPARE6   = 3'd6;
	localparam logic [2:0]  FN_SPARE7   = 3'd7;

	// reply word as it sits on m_tdata, lowest field last
	typedef struct packed {
		logic [CNT_W-1:0]  count;
		logic [STAT_W-1:0] status;
		logic              found;
		logic [VAL_W-1:0]  popped;
	} deq_reply_t;

	typedef struct packed {
		logic [2:0]       fn;
		logic [VAL_W-1:0] val;
		logic [4:0]       reps;
		logic             typed;
		deq_reply_t       exp;
	} plan_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OUT_W-1:0]     m_tdata;

	logic [VAL_W-1:0]     ring [DEPTH];
	int                   head;
	int                   fill;
	deq_reply_t           pending_replies [$];
	int                   errors;
	int                   sent;
	int                   src_idle;
	int                   snk_idle;
	int                   phase;
	int                   stall_cycles;

	// fn, value, reps, typed, then count, status, found, popped
	plan_row_t directed_plan [25] = '{
		'{deq_pkg::FN_POP_FRONT,  32'h0000_0000, 5'd1, 1'b1,
			'{5'd0,  deq_pkg::ST_EMPTY, 1'b0, 32'h0000_0000}},
		'{deq_pkg::FN_POP_BACK,   32'h0000_0000, 5'd1, 1'b1,
			'{5'd0,  deq_pkg::ST_EMPTY, 1'b0, 32'h0000_0000}},
		'{deq_pkg::FN_SEARCH,     32'h0000_0000, 5'd1, 1'b1,
			'{5'd0,  deq_pkg::ST_EMPTY, 1'b0, 32'h0000_0000}},
		'{deq_pkg::FN_CLEAR,      32'h0000_0000, 5'd1, 1'b1,
			'{5'd0,  deq_pkg::ST_OK,    1'b0, 32'h0000_0000}},
		'{FN_SPARE6,              32'hffff_ffff, 5'd1, 1'b1,
			'{5'd0,  deq_pkg::ST_OK,    1'b0, 32'h0000_0000}},
		'{FN_SPARE7,              32'h5555_aaaa, 5'd1, 1'b1,
			'{5'd0,  deq_pkg::ST_OK,    1'b0, 32'h0000_0000}},
		'{deq_pkg::FN_PUSH_BACK,  32'h7fff_ffff, 5'd1, 1'b1,
			'{5'd1,  deq_pkg::ST_OK,    1'b0, 32'h0000_0000}},
		'{deq_pkg::FN_PUSH_FRONT, 32'h8000_0000, 5'd1, 1'b1,
			'{5'd2,  deq_pkg::ST_OK,    1'b0, 32'h0000_0000}},
		'{deq_pkg::FN_SEARCH,     32'h8000_0000, 5'd1, 1'b1,
			'{5'd2,  deq_pkg::ST_OK,    1'b1, 32'h0000_0000}},
		'{deq_pkg::FN_SEARCH,     32'h7fff_ffff, 5'd1, 1'b1,
			'{5'd2,  deq_pkg::ST_OK,    1'b1, 32'h0000_0000}},
		'{deq_pkg::FN_SEARCH,     32'h0000_0000, 5'd1, 1'b1,
			'{5'd2,  deq_pkg::ST_OK,    1'b0, 32'h0000_0000}},
		'{deq_pkg::FN_POP_BACK,   32'h0000_0000, 5'd1, 1'b1,
			'{5'd1,  deq_pkg::ST_OK,    1'b0, 32'h7fff_ffff}},
		'{deq_pkg::FN_POP_FRONT,  32'h0000_0000, 5'd1, 1'b1,
			'{5'd0,  deq_pkg::ST_OK,    1'b0, 32'h8000_0000}},
		'{deq_pkg::FN_PUSH_FRONT, 32'h0000_0100, 5'd8, 1'b0, '0},
		'{deq_pkg::FN_PUSH_BACK,  32'h0000_0200, 5'd8, 1'b0, '0},
		'{deq_pkg::FN_PUSH_BACK,  32'h0000_0001, 5'd1, 1'b1,
			'{5'd16, deq_pkg::ST_FULL,  1'b0, 32'h0000_0000}},
		'{deq_pkg::FN_PUSH_FRONT, 32'h0000_0001, 5'd1, 1'b1,
			'{5'd16, deq_pkg::ST_FULL,  1'b0, 32'h0000_0000}},
		'{deq_pkg::FN_SEARCH,     32'h0000_0107, 5'd1, 1'b0, '0},
		'{deq_pkg::FN_SEARCH,     32'h0000_0207, 5'd1, 1'b0, '0},
		'{deq_pkg::FN_SEARCH,     32'h0000_0300, 5'd1, 1'b0, '0},
		'{FN_SPARE6,              32'h0000_0000, 5'd1, 1'b1,
			'{5'd16, deq_pkg::ST_OK,    1'b0, 32'h0000_0000}},
		'{deq_pkg::FN_POP_FRONT,  32'h0000_0000, 5'd1, 1'b0, '0},
		'{deq_pkg::FN_POP_BACK,   32'h0000_0000, 5'd1, 1'b0, '0},
		'{deq_pkg::FN_CLEAR,      32'h0000_0000, 5'd1, 1'b1,
			'{5'd0,  deq_pkg::ST_OK,    1'b0, 32'h0000_0000}},
		'{deq_pkg::FN_POP_BACK,   32'h0000_0000, 5'd1, 1'b1,
			'{5'd0,  deq_pkg::ST_EMPTY, 1'b0, 32'h0000_0000}}
	};

	double_ended_queue_with_search #(
		.DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #(PERIOD/2) clk = ~clk;

	function automatic deq_reply_t apply_request(input logic [2:0] fn, input logic [VAL_W-1:0] v);
		deq_reply_t r;
		r = '0;
		r.status = deq_pkg::ST_OK;
		case (fn)
			deq_pkg::FN_PUSH_BACK: begin
				if (fill >= DEPTH) begin
					r.status = deq_pkg::ST_FULL;
				end else begin
					ring[(head + fill) % DEPTH] = v;
					fill++;
				end
			end
			deq_pkg::FN_PUSH_FRONT: begin
				if (fill >= DEPTH) begin
					r.status = deq_pkg::ST_FULL;
				end else begin
					head = (head + DEPTH - 1) % DEPTH;
					ring[head] = v;
					fill++;
				end
			end
			deq_pkg::FN_POP_FRONT: begin
				if (fill == 0) begin
					r.status = deq_pkg::ST_EMPTY;
				end else begin
					r.popped = ring[head];
					head = (head + 1) % DEPTH;
					fill--;
				end
			end
			deq_pkg::FN_POP_BACK: begin
				if (fill == 0) begin
					r.status = deq_pkg::ST_EMPTY;
				end else begin
					r.popped = ring[(head + fill - 1) % DEPTH];
					fill--;
				end
			end
			deq_pkg::FN_SEARCH: begin
				if (fill == 0) begin
					r.status = deq_pkg::ST_EMPTY;
				end else begin
					for (int i = 0; i < fill; i++) begin
						if (ring[(head + i) % DEPTH] == v) r.found = 1'b1;
					end
				end
			end
			deq_pkg::FN_CLEAR: begin
				fill = 0;
				head = 0;
			end
			default: ;
		endcase
		r.count = fill[CNT_W-1:0];
		return r;
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 9);
		case (r)
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return VAL_W'($urandom_range(0, 3));
			default: return $urandom;
		endcase
	endfunction

	task automatic drive_word(input logic [2:0] fn, input logic [VAL_W-1:0] v,
			input logic typed, input deq_reply_t typed_reply);
		deq_reply_t r;
		phase = (sent / PHASE_LEN > 2) ? 2 : sent / PHASE_LEN;
		src_idle = (phase == 0) ? 31 : (phase == 1) ? 79 : 0;
		snk_idle = (phase == 0) ? 79 : (phase == 1) ? 31 : 0;
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_W-VAL_W-FUNC_W){1'b0}}, v, fn};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = apply_request(fn, v);
		pending_replies.push_back(typed ? typed_reply : r);
		sent++;
	endtask

	// result checker
	always @(posedge clk) begin
		deq_reply_t got;
		deq_reply_t e;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_replies.size() == 0) begin
				$error("unexpected word %h", m_tdata);
				errors++;
			end else begin
				e = pending_replies.pop_front();
				if (got.popped !== e.popped) begin
					$error("popped_value: expected %0d, got %0d", $signed(e.popped),
						$signed(got.popped));
					errors++;
				end
				if (got.found !== e.found) begin
					$error("found: expected %0d, got %0d", e.found, got.found);
					errors++;
				end
				if (got.status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, got.status);
					errors++;
				end
				if (got.count !== e.count) begin
					$error("count: expected %0d, got %0d", e.count, got.count);
					errors++;
				end
			end
		end
	end

	// receiver: random stalls, one long hold-off when the no-idle phase starts
	initial begin
		int  hold_left;
		bit  held;
		hold_left = 0;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (phase == 2 && !held) begin
				held = 1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= snk_idle);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles = 0;
		end else if (arst_n) begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("** double_ended_queue_with_search: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		logic [2:0]       fn;
		logic [VAL_W-1:0] v;
		int               push_pct;
		int unsigned      r;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		head = 0;
		fill = 0;
		errors = 0;
		sent = 0;
		phase = 0;
		src_idle = 31;
		snk_idle = 79;
		stall_cycles = 0;
		push_pct = 50;
		foreach (ring[i]) ring[i] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_plan[k]) begin
			for (int j = 0; j < directed_plan[k].reps; j++) begin
				drive_word(directed_plan[k].fn, directed_plan[k].val + VAL_W'(j),
					directed_plan[k].typed, directed_plan[k].exp);
			end
		end

		for (int n = 0; n < RAND_ITEMS; n++) begin
			// drift between filling and draining so every occupancy is visited
			if (n % 50 == 0) push_pct = $urandom_range(15, 85);
			v = pick_value();
			r = $urandom_range(0, 99);
			if (r < 2) begin
				fn = deq_pkg::FN_CLEAR;
			end else if (r < 4) begin
				fn = r[0] ? FN_SPARE7 : FN_SPARE6;
			end else if ($urandom_range(0, 99) < push_pct) begin
				fn = $urandom_range(0, 1) ? deq_pkg::FN_PUSH_FRONT : deq_pkg::FN_PUSH_BACK;
			end else begin
				case ($urandom_range(0, 2))
					0: fn = deq_pkg::FN_POP_FRONT;
					1: fn = deq_pkg::FN_POP_BACK;
					default: begin
						fn = deq_pkg::FN_SEARCH;
						if (fill > 0 && $urandom_range(0, 1))
							v = ring[(head + $urandom_range(0, fill - 1)) % DEPTH];
					end
				endcase
			end
			drive_word(fn, v, 1'b0, '0);
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (pending_replies.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("** double_ended_queue_with_search: PASSED **");
		end else begin
			$display("** double_ended_queue_with_search: FAILED **");
		end
		$finish;
	end

endmodule
